// ----- hdl/ftpt_pkg.sv -----
// Shared constants and types for the FIFO TLB page translator.
package ftpt_pkg;

    // Fixed address width of the logical and physical address fields
    localparam int ADDR_W = 16;

    // Default geometry
    localparam int DEF_TLB_ENTRIES = 32;
    localparam int DEF_PAGE_COUNT  = 256;
    localparam int DEF_OFFSET_BITS = 8;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Status from the back end to the front end
    typedef struct packed {
        logic init_done;   // page table clearing pass finished
        logic upd_valid;   // TLB refill transfer this cycle
    } t_back_stat;

endpackage

// ----- hdl/ftpt_queue.sv -----
// Small FIFO that decouples the lookup front end from the page table back end.
module ftpt_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_not_full,
    input  logic             i_pop,
    output logic             o_not_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int DEPTH = ftpt_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_not_full  = (r_count != CNT_W'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_data      = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- hdl/ftpt_front.sv -----
// Front end: input transfer, fully associative TLB lookup and TLB refill.
module ftpt_front #(
    parameter int TLB_ENTRIES = ftpt_pkg::DEF_TLB_ENTRIES,
    parameter int PAGE_COUNT  = ftpt_pkg::DEF_PAGE_COUNT,
    parameter int OFFSET_BITS = ftpt_pkg::DEF_OFFSET_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [ftpt_pkg::ADDR_W-1:0] i_logical_address,
    // queue push side
    output logic                        o_push,
    output logic                        o_hit,
    output logic [$clog2(PAGE_COUNT)-1:0] o_page,
    output logic [((OFFSET_BITS < ftpt_pkg::ADDR_W) ?
                   (ftpt_pkg::ADDR_W - OFFSET_BITS) : 1)-1:0] o_frame,
    output logic [OFFSET_BITS-1:0]      o_offset,
    input  logic                        i_q_not_full,
    // refill from the back end
    input  ftpt_pkg::t_back_stat        i_stat,
    input  logic [$clog2(PAGE_COUNT)-1:0] i_upd_page,
    input  logic [((OFFSET_BITS < ftpt_pkg::ADDR_W) ?
                   (ftpt_pkg::ADDR_W - OFFSET_BITS) : 1)-1:0] i_upd_frame
);

    localparam int PAGE_W  = $clog2(PAGE_COUNT);
    localparam int FRAME_W = (OFFSET_BITS < ftpt_pkg::ADDR_W) ?
                             (ftpt_pkg::ADDR_W - OFFSET_BITS) : 1;
    localparam int IDX_W   = $clog2(TLB_ENTRIES);

    logic [PAGE_W-1:0]          r_tag   [TLB_ENTRIES];
    logic [FRAME_W-1:0]         r_frame [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0]     r_valid;
    logic [IDX_W-1:0]           r_ptr;
    logic                       r_miss_pend;

    logic [ftpt_pkg::ADDR_W-1:0] w_shift;
    logic [PAGE_W-1:0]          w_page;
    logic [TLB_ENTRIES-1:0]     w_match;
    logic [FRAME_W-1:0]         w_frame;

    // Split the address into page and offset
    assign w_shift  = i_logical_address >> OFFSET_BITS;
    assign w_page   = w_shift[PAGE_W-1:0];
    assign o_offset = i_logical_address[OFFSET_BITS-1:0];

    // Compare every valid entry against the page
    always_comb begin
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            w_match[i] = r_valid[i] && (r_tag[i] == w_page);
        end
    end

    // Pick the frame of the lowest matching entry
    always_comb begin
        w_frame = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_frame = r_frame[i];
            end
        end
    end

    // Hold input while the page table is still clearing, a refill is due or the queue is full
    assign o_in_ready = i_stat.init_done && !r_miss_pend && i_q_not_full;
    assign o_push     = i_in_valid && o_in_ready;
    assign o_hit      = |w_match;
    assign o_page     = w_page;
    assign o_frame    = w_frame;

    // Track the outstanding miss and the round-robin slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_ptr       <= '0;
            r_miss_pend <= 1'b0;
        end else begin
            if (o_push && !o_hit) begin
                r_miss_pend <= 1'b1;
            end else if (i_stat.upd_valid) begin
                r_miss_pend <= 1'b0;
            end
            if (i_stat.upd_valid) begin
                r_valid[r_ptr] <= 1'b1;
                r_ptr          <= (r_ptr == IDX_W'(TLB_ENTRIES - 1)) ? '0 : r_ptr + 1'b1;
            end
        end
    end

    // Write the refilled page and frame into the oldest slot
    always_ff @(posedge i_clk) begin
        if (i_stat.upd_valid) begin
            r_tag[r_ptr]   <= i_upd_page;
            r_frame[r_ptr] <= i_upd_frame;
        end
    end

    // A page lives in at most one valid entry
    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("front: page matches several TLB entries");

    // A refill only arrives for a miss that is outstanding
    a_upd_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.upd_valid |-> r_miss_pend)
        else $error("front: TLB refill without an outstanding miss");

endmodule

// ----- hdl/ftpt_back.sv -----
// Back end: page table memory, frame allocation, clearing pass and result register.
module ftpt_back #(
    parameter int PAGE_COUNT  = ftpt_pkg::DEF_PAGE_COUNT,
    parameter int OFFSET_BITS = ftpt_pkg::DEF_OFFSET_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // queue pop side
    input  logic                        i_q_not_empty,
    output logic                        o_pop,
    input  logic                        i_hit,
    input  logic [$clog2(PAGE_COUNT)-1:0] i_page,
    input  logic [((OFFSET_BITS < ftpt_pkg::ADDR_W) ?
                   (ftpt_pkg::ADDR_W - OFFSET_BITS) : 1)-1:0] i_frame,
    input  logic [OFFSET_BITS-1:0]      i_offset,
    // refill to the front end
    output ftpt_pkg::t_back_stat        o_stat,
    output logic [$clog2(PAGE_COUNT)-1:0] o_upd_page,
    output logic [((OFFSET_BITS < ftpt_pkg::ADDR_W) ?
                   (ftpt_pkg::ADDR_W - OFFSET_BITS) : 1)-1:0] o_upd_frame,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [ftpt_pkg::ADDR_W-1:0] o_physical_address,
    output logic                        o_tlb_hit,
    output logic                        o_new_mapping
);

    localparam int PAGE_W  = $clog2(PAGE_COUNT);
    localparam int FRAME_W = (OFFSET_BITS < ftpt_pkg::ADDR_W) ?
                             (ftpt_pkg::ADDR_W - OFFSET_BITS) : 1;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;

    // Page table entry: mapped flag over frame number
    logic [FRAME_W:0]       r_pt [PAGE_COUNT];
    logic [FRAME_W:0]       r_rd_data;

    logic [1:0]             r_state, n_state;
    logic [PAGE_W-1:0]      r_clr_idx;
    logic [FRAME_W-1:0]     r_next_frame;
    logic [PAGE_W-1:0]      r_page;
    logic [OFFSET_BITS-1:0] r_offset;

    logic                   r_out_valid, n_out_valid;
    logic [ftpt_pkg::ADDR_W-1:0] r_phys, n_phys;
    logic                   r_hit, n_hit;
    logic                   r_fresh, n_fresh;

    logic                   w_out_free;
    logic                   w_mapped;
    logic [FRAME_W-1:0]     w_look_frame;
    logic                   w_alloc;
    logic                   w_rd_en;
    logic                   w_wr_en;
    logic [PAGE_W-1:0]      w_wr_addr;
    logic [FRAME_W:0]       w_wr_data;

    function automatic logic [ftpt_pkg::ADDR_W-1:0] phys_addr(
        input logic [FRAME_W-1:0]     frame,
        input logic [OFFSET_BITS-1:0] offset
    );
        logic [ftpt_pkg::ADDR_W-1:0] base;
        base      = ftpt_pkg::ADDR_W'(frame) << OFFSET_BITS;
        phys_addr = base | ftpt_pkg::ADDR_W'(offset);
    endfunction

    assign w_out_free   = !r_out_valid || i_out_ready;
    assign o_pop        = (r_state == ST_IDLE) && i_q_not_empty && w_out_free;
    assign w_rd_en      = o_pop && !i_hit;
    assign w_mapped     = r_rd_data[FRAME_W];
    assign w_look_frame = w_mapped ? r_rd_data[FRAME_W-1:0] : r_next_frame;
    assign w_alloc      = (r_state == ST_LOOK) && !w_mapped;

    // Page table write port: clearing pass or fresh allocation
    assign w_wr_en   = (r_state == ST_CLEAR) || w_alloc;
    assign w_wr_addr = (r_state == ST_CLEAR) ? r_clr_idx : r_page;
    assign w_wr_data = (r_state == ST_CLEAR) ? '0 : {1'b1, r_next_frame};

    // Refill transfer to the front end
    assign o_stat.init_done = (r_state != ST_CLEAR);
    assign o_stat.upd_valid = (r_state == ST_LOOK);
    assign o_upd_page       = r_page;
    assign o_upd_frame      = w_look_frame;

    // Sequence clearing pass, queue pops and page table lookups
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        n_phys      = r_phys;
        n_hit       = r_hit;
        n_fresh     = r_fresh;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_idx == PAGE_W'(PAGE_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (o_pop) begin
                    if (i_hit) begin
                        n_out_valid = 1'b1;
                        n_phys      = phys_addr(i_frame, i_offset);
                        n_hit       = 1'b1;
                        n_fresh     = 1'b0;
                    end else begin
                        n_state = ST_LOOK;
                    end
                end
            end
            ST_LOOK: begin
                n_out_valid = 1'b1;
                n_phys      = phys_addr(w_look_frame, r_offset);
                n_hit       = 1'b0;
                n_fresh     = !w_mapped;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_idx    <= '0;
            r_next_frame <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (w_alloc) begin
                r_next_frame <= r_next_frame + 1'b1;
            end
        end
    end

    // Hold the missed item and the result payload
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_page   <= i_page;
            r_offset <= i_offset;
        end
        r_phys  <= n_phys;
        r_hit   <= n_hit;
        r_fresh <= n_fresh;
    end

    // Page table memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_pt[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_pt[i_page];
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_physical_address = r_phys;
    assign o_tlb_hit          = r_hit;
    assign o_new_mapping      = r_fresh;

    // A lookup always follows a pop from idle
    a_look_after_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOK) |-> ($past(r_state) == ST_IDLE))
        else $error("back: page table lookup without a pop");

    // Each fresh mapping advances the frame counter by one
    a_frame_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_alloc |=> (r_next_frame == $past(r_next_frame) + 1'b1))
        else $error("back: frame counter did not advance on allocation");

endmodule

// ----- hdl/fifo_tlb_page_translator_top.sv -----
// Top level of the FIFO TLB page translator.
// Translates one 16-bit logical address per transfer into frame * 2^OFFSET_BITS + offset,
// with a TLB hit flag and a new mapping flag, one result per address in input order. A TLB
// hit costs one cycle per address at the input while the queue has room: hits stream through
// the queue back to back. After a miss transfer the input is held through the queue pop with
// its registered page table read and through the TLB refill write, so the refilled entry is
// visible to the next lookup. Earlier items in the queue or a stalled output hold it longer.
// After reset the block clears the page table and accepts no address until that pass ends.
// PAGE_COUNT must be a power of two; frames are handed out in order and the oldest TLB entry
// is replaced.
module fifo_tlb_page_translator_top #(
    parameter int TLB_ENTRIES = ftpt_pkg::DEF_TLB_ENTRIES,
    parameter int PAGE_COUNT  = ftpt_pkg::DEF_PAGE_COUNT,
    parameter int OFFSET_BITS = ftpt_pkg::DEF_OFFSET_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [ftpt_pkg::ADDR_W-1:0] i_logical_address,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [ftpt_pkg::ADDR_W-1:0] o_physical_address,
    output logic                        o_tlb_hit,
    output logic                        o_new_mapping
);

    localparam int PAGE_W  = $clog2(PAGE_COUNT);
    localparam int FRAME_W = (OFFSET_BITS < ftpt_pkg::ADDR_W) ?
                             (ftpt_pkg::ADDR_W - OFFSET_BITS) : 1;
    localparam int Q_W     = 1 + PAGE_W + FRAME_W + OFFSET_BITS;

    logic                   w_push, w_pop;
    logic                   w_q_not_full, w_q_not_empty;
    logic                   w_f_hit;
    logic [PAGE_W-1:0]      w_f_page;
    logic [FRAME_W-1:0]     w_f_frame;
    logic [OFFSET_BITS-1:0] w_f_offset;
    logic [Q_W-1:0]         w_q_in, w_q_out;
    logic                   w_b_hit;
    logic [PAGE_W-1:0]      w_b_page;
    logic [FRAME_W-1:0]     w_b_frame;
    logic [OFFSET_BITS-1:0] w_b_offset;
    ftpt_pkg::t_back_stat   w_stat;
    logic [PAGE_W-1:0]      w_upd_page;
    logic [FRAME_W-1:0]     w_upd_frame;

    ftpt_front #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .PAGE_COUNT  (PAGE_COUNT),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_logical_address (i_logical_address),
        .o_push            (w_push),
        .o_hit             (w_f_hit),
        .o_page            (w_f_page),
        .o_frame           (w_f_frame),
        .o_offset          (w_f_offset),
        .i_q_not_full      (w_q_not_full),
        .i_stat            (w_stat),
        .i_upd_page        (w_upd_page),
        .i_upd_frame       (w_upd_frame)
    );

    // Pack the classified item for the queue
    assign w_q_in = {w_f_hit, w_f_page, w_f_frame, w_f_offset};
    assign {w_b_hit, w_b_page, w_b_frame, w_b_offset} = w_q_out;

    ftpt_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_data      (w_q_in),
        .o_not_full  (w_q_not_full),
        .i_pop       (w_pop),
        .o_not_empty (w_q_not_empty),
        .o_data      (w_q_out)
    );

    ftpt_back #(
        .PAGE_COUNT  (PAGE_COUNT),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_not_empty      (w_q_not_empty),
        .o_pop              (w_pop),
        .i_hit              (w_b_hit),
        .i_page             (w_b_page),
        .i_frame            (w_b_frame),
        .i_offset           (w_b_offset),
        .o_stat             (w_stat),
        .o_upd_page         (w_upd_page),
        .o_upd_frame        (w_upd_frame),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_physical_address (o_physical_address),
        .o_tlb_hit          (o_tlb_hit),
        .o_new_mapping      (o_new_mapping)
    );

endmodule
